### rtl/bbs_pkg.sv
// Shared constants and types for the Bollinger band signal block.
package bbs_pkg;

  // Field widths
  localparam int PRICE_W    = 24;
  localparam int K_W        = 4;
  localparam int QTY_W      = 16;
  localparam int SIG_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Default window length
  localparam int WINDOW_DEF = 20;

  // Register reset values
  localparam logic [K_W-1:0]   BAND_K_RST     = 4'd2;
  localparam logic [QTY_W-1:0] ORDER_SIZE_RST = 16'd100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAND_K     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_SIZE = 1'b1;

  // Signal codes
  localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
  localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
  localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

  // Status from the arithmetic core to the top level
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SIG_W-1:0] sig;
  } bbs_res_t;

endpackage

### rtl/bollinger_band_signal.sv
// Bollinger band signal: one mid price in, one signal result out per price.
// The result is registered in CMP, once the output register can take it.
// A new price is taken only while the sequencer is idle: the single shared multiplier
//   works through nine products under the sequencer, and the input stalls meanwhile.
// Reset (rst, synchronous): clears window count, sums, sequencer and output valid;
//   band_k returns to 2 and order_size to 100; the price ring is not cleared.
module bollinger_band_signal #(
  parameter int WINDOW = bbs_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bbs_pkg::PRICE_W-1:0]    tick_price,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bbs_pkg::SIG_W-1:0]      signal,
  output logic [bbs_pkg::PRICE_W-1:0]    order_price,
  output logic [bbs_pkg::QTY_W-1:0]      order_quantity,
  output logic                           window_full,
  input  logic                           write_enable,
  input  logic [bbs_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [bbs_pkg::CFG_DATA_W-1:0] write_data
);

  logic                        accept;
  logic                        take;
  logic [bbs_pkg::K_W-1:0]     band_k;
  logic [bbs_pkg::QTY_W-1:0]   order_size;
  logic [bbs_pkg::PRICE_W-1:0] price;
  logic [bbs_pkg::PRICE_W-1:0] old_price;
  logic                        full;
  bbs_pkg::bbs_res_t           res;

  assign in_stall = res.busy;
  assign accept   = in_valid && !in_stall;
  assign take     = !out_valid || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      band_k     <= bbs_pkg::BAND_K_RST;
      order_size <= bbs_pkg::ORDER_SIZE_RST;
    end else if (write_enable) begin
      unique case (write_index)
        bbs_pkg::REG_BAND_K:     band_k     <= write_data[bbs_pkg::K_W-1:0];
        bbs_pkg::REG_ORDER_SIZE: order_size <= write_data[bbs_pkg::QTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted price for the whole computation
  always_ff @(posedge clk) begin
    if (accept) begin
      price <= tick_price;
    end
  end

  bbs_window #(.WINDOW(WINDOW)) u_window (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .price     (tick_price),
    .old_price (old_price),
    .full      (full)
  );

  bbs_core #(.WINDOW(WINDOW)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .take      (take),
    .full      (full),
    .band_k    (band_k),
    .price     (price),
    .old_price (old_price),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      signal         <= res.sig;
      order_price    <= price;
      order_quantity <= (res.sig != bbs_pkg::SIG_NONE) ? order_size : '0;
      window_full    <= full;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("accepted a transfer but not busy");

  a_sig_needs_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (signal != bbs_pkg::SIG_NONE) |-> window_full)
    else $error("signal before window full");

  a_qty_zero_on_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && (signal == bbs_pkg::SIG_NONE) |-> (order_quantity == '0))
    else $error("quantity without signal");

  a_result_from_core: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(res.busy))
    else $error("result without computation");

endmodule

### rtl/bbs_mul.sv
// Shared unsigned multiplier with registered product.
module bbs_mul #(
  parameter int W = 29
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] prod
);

  logic [2*W-1:0] a_x;
  logic [2*W-1:0] b_x;

  assign a_x = (2*W)'(a);
  assign b_x = (2*W)'(b);

  // One product per cycle, registered
  always_ff @(posedge clk) begin
    prod <= a_x * b_x;
  end

endmodule

### rtl/bbs_window.sv
// Price ring, write pointer and sample count for the band window.
module bbs_window #(
  parameter int WINDOW = bbs_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [bbs_pkg::PRICE_W-1:0] price,
  output logic [bbs_pkg::PRICE_W-1:0] old_price,
  output logic                       full
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  logic [bbs_pkg::PRICE_W-1:0] ring [WINDOW];
  logic [PTR_W-1:0]            ptr;
  logic [CNT_W-1:0]            seen;

  // Pointer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      seen <= '0;
      full <= 1'b0;
    end else if (push) begin
      ptr  <= (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
      if (seen != CNT_FULL) begin
        seen <= seen + CNT_W'(1);
      end
      full <= (seen == CNT_FULL) || (seen == CNT_LAST);
    end
  end

  // Ring store; evicted price reads as zero until the window has filled
  always_ff @(posedge clk) begin
    if (push) begin
      old_price  <= (seen == CNT_FULL) ? ring[ptr] : '0;
      ring[ptr]  <= price;
    end
  end

endmodule

### rtl/bbs_core.sv
// Sequencer and accumulators around the shared multiplier for the band test.
module bbs_core #(
  parameter int WINDOW = bbs_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        take,
  input  logic                        full,
  input  logic [bbs_pkg::K_W-1:0]     band_k,
  input  logic [bbs_pkg::PRICE_W-1:0] price,
  input  logic [bbs_pkg::PRICE_W-1:0] old_price,
  output bbs_pkg::bbs_res_t           res
);

  localparam int H    = bbs_pkg::PRICE_W + $clog2(WINDOW);
  localparam int SQ_W = 2 * bbs_pkg::PRICE_W + $clog2(WINDOW);
  localparam int KD_W = 2 * H + 2 * bbs_pkg::K_W;
  localparam logic [H-1:0] N = H'(WINDOW);

  typedef enum logic [3:0] {
    IDLE, SQ_NEW, SQ_OLD, SS, NP, NQ_LO, NQ_HI, MM, KD_LO, KD_HI, KD_ADD, CMP
  } state_t;

  state_t                        state;
  logic [H-1:0]                  s;
  logic [SQ_W-1:0]               q;
  logic [KD_W-1:0]               acc;
  logic [H-1:0]                  np;
  logic [H-1:0]                  m;
  logic [2*H-1:0]                m2;
  logic                          buy;
  logic                          sell;
  logic [2*bbs_pkg::K_W-1:0]     k2;
  logic [H-1:0]                  mul_a;
  logic [H-1:0]                  mul_b;
  logic [2*H-1:0]                prod;
  logic [bbs_pkg::SIG_W-1:0]     sig;

  assign k2 = {{bbs_pkg::K_W{1'b0}}, band_k} * {{bbs_pkg::K_W{1'b0}}, band_k};

  // Operand selection for the shared multiplier
  always_comb begin
    unique case (state)
      SQ_NEW: begin mul_a = H'(price);     mul_b = H'(price);     end
      SQ_OLD: begin mul_a = H'(old_price); mul_b = H'(old_price); end
      SS:     begin mul_a = s;             mul_b = s;             end
      NP:     begin mul_a = N;             mul_b = H'(price);     end
      NQ_LO:  begin mul_a = N;             mul_b = q[H-1:0];      end
      NQ_HI:  begin mul_a = N;             mul_b = H'(q[SQ_W-1:H]); end
      MM:     begin mul_a = m;             mul_b = m;             end
      KD_LO:  begin mul_a = H'(k2);        mul_b = acc[H-1:0];    end
      KD_HI:  begin mul_a = H'(k2);        mul_b = acc[2*H-1:H];  end
      default: begin mul_a = '0;           mul_b = '0;            end
    endcase
  end

  bbs_mul #(.W(H)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Final decision: |S - N*p|^2 against k^2 * (N*Q - S^2)
  always_comb begin
    if (full && (buy || sell) && (KD_W'(m2) > acc)) begin
      sig = buy ? bbs_pkg::SIG_BUY : bbs_pkg::SIG_SELL;
    end else begin
      sig = bbs_pkg::SIG_NONE;
    end
  end

  assign res.busy = (state != IDLE);
  assign res.done = (state == CMP) && take;
  assign res.sig  = sig;

  // Sequencer; SQ_NEW..KD_HI each issue one product, SQ_OLD..KD_ADD fold in the one before
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      s     <= '0;
      q     <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= SQ_NEW;
          end
        end
        SQ_NEW: begin
          s     <= s - H'(old_price) + H'(price);
          state <= SQ_OLD;
        end
        SQ_OLD: begin
          q     <= q + SQ_W'(prod);
          state <= SS;
        end
        SS: begin
          q     <= q - SQ_W'(prod);
          state <= NP;
        end
        NP: begin
          acc   <= '0 - KD_W'(prod);
          state <= NQ_LO;
        end
        NQ_LO: begin
          np    <= prod[H-1:0];
          state <= NQ_HI;
        end
        NQ_HI: begin
          acc   <= acc + KD_W'(prod);
          buy   <= (s > np);
          sell  <= (np > s);
          m     <= (s > np) ? s - np : np - s;
          state <= MM;
        end
        MM: begin
          acc   <= acc + (KD_W'(prod) << H);
          state <= KD_LO;
        end
        KD_LO: begin
          m2    <= prod;
          state <= KD_HI;
        end
        KD_HI: begin
          acc   <= KD_W'(prod);
          state <= KD_ADD;
        end
        KD_ADD: begin
          acc   <= acc + (KD_W'(prod) << H);
          state <= CMP;
        end
        CMP: begin
          if (take) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Checks on the sequencer
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == IDLE))
    else $error("start outside idle");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == SQ_NEW))
    else $error("sequencer did not start");

  a_sig_needs_side: assert property (@(posedge clk) disable iff (rst)
    (state == CMP) && (sig != bbs_pkg::SIG_NONE) |-> (buy != sell))
    else $error("signal without a side");

endmodule
